// ----- design/b2il_pkg.sv -----
// ----------------------------------------------------------------------------
// b2il_pkg
// Shared types and constants for the bitmap to index list block.
// ----------------------------------------------------------------------------
package b2il_pkg;

    localparam int unsigned BYTE_SHIFT = 3;                 // bits per byte, log2
    localparam int unsigned BYTE_BITS  = 1 << BYTE_SHIFT;
    localparam int unsigned IDX_W      = 32;                // element index width
    localparam int unsigned POS_W      = IDX_W - BYTE_SHIFT; // byte position width
    localparam logic [BYTE_SHIFT-1:0] BIT_MAX = '1;          // last bit of a byte

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CLOSE
    } state_t;

endpackage

// ----- design/bitmap_to_index_list.sv -----
// ----------------------------------------------------------------------------
// bitmap_to_index_list
// Turns a selection bitmap, one byte per item, into an ascending list of
// selected element positions followed by a closing item with the total.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+------------------------------------
//  s_*     | in  | s_tvalid / s_tready    | s_tdata[7:0] = sel_byte
//  m_*     | out | m_tvalid / m_tready    | m_tdata = element_index, selected_total
//          |     |                        | m_tuser = is_done, m_tlast = run_last
//  cfg_*   | in  | cfg_valid / cfg_ready  | cfg_data = element_count
//
//  Sequence: an input item is taken in ST_IDLE, then a sequencer walks its
//  eight bits, one per cycle while the output slot is free, through a single
//  range compare against element_count, skipped when element_count is zero.
//  The final byte adds the closing item in ST_CLOSE. No new item is taken
//  until ST_IDLE again. Stalls: one output register; the bit walk holds
//  while it is full and not being taken.
//  Reset: asynchronous, clears counters, element_count and the output valid.
//  cfg_ready is always high; writes are expected only while idle.
//
module bitmap_to_index_list
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] sel_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,     // [31:0] element_index, [63:32] selected_total
    output logic        m_tuser,     // [0] is_done
    output logic        m_tlast,     // run_last

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data     // element_count
);

    localparam int unsigned IW = b2il_pkg::IDX_W;
    localparam int unsigned PW = b2il_pkg::POS_W;
    localparam int unsigned SW = b2il_pkg::BYTE_SHIFT;
    localparam int unsigned BB = b2il_pkg::BYTE_BITS;

    // control state
    b2il_pkg::state_t state_reg, state_next;
    logic [SW-1:0]    k_reg, k_next;           // bit under test
    logic             final_reg, final_next;   // current byte closes the bitmap
    logic [PW-1:0]    pos_reg, pos_next;       // next expected byte
    logic [IW-1:0]    count_reg, count_next;   // selected so far
    logic [IW-1:0]    ec_reg, ec_next;         // element_count
    logic             out_valid_reg, out_valid_next;

    // payload
    logic [BB-1:0]    bits_reg, bits_next;
    logic [PW-1:0]    base_reg, base_next;     // byte position of current byte
    logic [IW-1:0]    out_index_reg, out_index_next;
    logic [IW-1:0]    out_total_reg, out_total_next;
    logic             out_done_reg, out_done_next;
    logic             out_last_reg, out_last_next;

    // datapath
    logic             slot_free;
    logic [IW-1:0]    ec_minus;
    logic [PW-1:0]    last_byte;
    logic             accept_final;
    logic [IW-1:0]    scan_pos;
    logic             hit;
    logic [BB-1:0]    higher_bits;
    logic [IW-1:0]    count_inc;

    assign slot_free   = !out_valid_reg || m_tready;
    assign ec_minus    = ec_reg - IW'(1);
    assign last_byte   = ec_minus[IW-1:SW];
    assign accept_final = (ec_reg == '0) || (pos_reg >= last_byte);

    // the one shared compare: is the bit under test inside the bitmap
    assign scan_pos    = {base_reg, k_reg};
    assign hit         = bits_reg[k_reg] && (scan_pos < ec_reg);
    // set bits above the one under test; on a non-final byte all are in range
    assign higher_bits = (bits_reg >> k_reg) >> 1;
    assign count_inc   = count_reg + IW'(1);

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        final_next     = final_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        ec_next        = ec_reg;
        bits_next      = bits_reg;
        base_next      = base_reg;
        out_index_next = out_index_reg;
        out_total_next = out_total_reg;
        out_done_next  = out_done_reg;
        out_last_next  = out_last_reg;
        out_valid_next = m_tready ? 1'b0 : out_valid_reg;

        if (cfg_valid)
        begin
            ec_next = cfg_data;
        end

        unique case (state_reg)
            b2il_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    bits_next  = s_tdata;
                    base_next  = pos_reg;
                    k_next     = '0;
                    final_next = accept_final;
                    pos_next   = accept_final ? pos_reg : pos_reg + PW'(1);
                    state_next = (ec_reg == '0) ? b2il_pkg::ST_CLOSE : b2il_pkg::ST_SCAN;
                end
            end

            b2il_pkg::ST_SCAN:
            begin
                if (slot_free)
                begin
                    if (hit)
                    begin
                        out_valid_next = 1'b1;
                        out_index_next = scan_pos;
                        out_total_next = count_inc;
                        out_done_next  = 1'b0;
                        out_last_next  = !final_reg && (higher_bits == '0);
                        count_next     = count_inc;
                    end
                    k_next = k_reg + SW'(1);
                    if (k_reg == b2il_pkg::BIT_MAX)
                    begin
                        state_next = final_reg ? b2il_pkg::ST_CLOSE : b2il_pkg::ST_IDLE;
                    end
                end
            end

            b2il_pkg::ST_CLOSE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = '0;
                    out_total_next = count_reg;
                    out_done_next  = 1'b1;
                    out_last_next  = 1'b1;
                    count_next     = '0;
                    pos_next       = '0;
                    state_next     = b2il_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = b2il_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= b2il_pkg::ST_IDLE;
            k_reg         <= '0;
            final_reg     <= 1'b0;
            pos_reg       <= '0;
            count_reg     <= '0;
            ec_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            final_reg     <= final_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            ec_reg        <= ec_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg      <= bits_next;
        base_reg      <= base_next;
        out_index_reg <= out_index_next;
        out_total_reg <= out_total_next;
        out_done_reg  <= out_done_next;
        out_last_reg  <= out_last_next;
    end

    assign s_tready  = (state_reg == b2il_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {out_total_reg, out_index_reg};
    assign m_tuser   = out_done_reg;
    assign m_tlast   = out_last_reg;

endmodule

// ----- design/b2il_checker.sv -----
// ----------------------------------------------------------------------------
// b2il_checker
// Port-level checks for bitmap_to_index_list, bound to the top level.
// ----------------------------------------------------------------------------
module b2il_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // stalled output holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tuser) && $stable(m_tlast))
        else $error("output item changed while stalled");

    // closing item always ends the run of its byte
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("closing item without run end");

    // closing item carries index zero
    a_done_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[31:0] == 32'd0)
        else $error("closing item with non-zero index");

    // one byte at a time: busy after an accepted item
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again before bit walk");

endmodule

bind bitmap_to_index_list b2il_checker u_b2il_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ----- verif/bitmap_to_index_list_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_to_index_list_tb
// Self-checking bench: selection bytes in, predicted index list compared out.
// A local predictor follows every accepted byte and queues the indices and
// closing item it should cause. Directed bitmaps cover the edge cases, and a
// long random part follows. Both stream sides idle in random bursts.
// ----------------------------------------------------------------------------
module bitmap_to_index_list_tb;

    localparam int unsigned IDX_W      = b2il_pkg::IDX_W;
    localparam int unsigned POS_W      = b2il_pkg::POS_W;
    localparam int unsigned BYTE_SHIFT = b2il_pkg::BYTE_SHIFT;
    localparam int unsigned BYTE_BITS  = b2il_pkg::BYTE_BITS;

    localparam int CYCLE_LIMIT   = 400000;  // far above the slowest legal run
    localparam int IDLE_PAUSE    = 16;      // one byte walk plus close, with margin
    localparam int RANDOM_ITEMS  = 345;
    localparam int QUIET_TAIL    = 50;      // last items run with no idling
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             done;
        logic [IDX_W-1:0] total;
        logic             last;
    } index_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;      // [7:0] sel_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;      // [31:0] element_index, [63:32] selected_total
    logic        m_tuser;      // [0] is_done
    logic        m_tlast;      // run_last
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;     // element_count

    // predictor state, mirrors the block
    logic [31:0]      model_count;
    logic [POS_W-1:0] model_pos;
    logic [31:0]      model_selected;

    logic [7:0]      byte_fifo[$];        // bytes waiting to be offered
    index_result_t   pending_results[$];  // predicted, not yet seen

    int  items_sent;
    int  items_accepted;
    int  results_checked;
    int  closes_seen;
    int  count_writes;
    int  mismatch_count;
    int  cycle_count;
    int  src_gap;
    int  sink_gap;
    bit  quiet;

    bitmap_to_index_list u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor: one accepted byte gives its selected indices in order,
    // then the closing item if this byte is (or is taken as) the final one.
    // ------------------------------------------------------------------
    task automatic predict_byte_results(input logic [7:0] sel);
        index_result_t burst[9];
        int            n;
        logic [31:0]   last_byte;
        logic [32:0]   pos;
        bit            final_byte;
        n = 0;
        if (model_count == '0)
        begin
            final_byte = 1'b1;
        end
        else
        begin
            last_byte  = (model_count - 32'd1) >> BYTE_SHIFT;
            final_byte = ({{BYTE_SHIFT{1'b0}}, model_pos} >= last_byte);
            for (int k = 0; k < BYTE_BITS; k++)
            begin
                pos = {1'b0, model_pos, {BYTE_SHIFT{1'b0}}} + 33'(k);
                if (sel[k] && pos < {1'b0, model_count})
                begin
                    model_selected = model_selected + 32'd1;
                    burst[n] = '{index: pos[31:0], done: 1'b0,
                                 total: model_selected, last: 1'b0};
                    n++;
                end
            end
        end
        if (final_byte)
        begin
            burst[n] = '{index: '0, done: 1'b1, total: model_selected, last: 1'b0};
            n++;
            model_pos      = '0;
            model_selected = '0;
        end
        else
        begin
            model_pos = model_pos + POS_W'(1);   // wraps at the position width
        end
        if (n > 0)
            burst[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            pending_results.push_back(burst[i]);
    endtask

    task automatic check_result(input index_result_t got);
        index_result_t want;
        if (pending_results.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("[%0t] unexpected item: index %0d done %0b total %0d last %0b",
                         $realtime, got.index, got.done, got.total, got.last);
        end
        else
        begin
            want = pending_results.pop_front();
            results_checked++;
            if (got.done)
                closes_seen++;
            if (got.index !== want.index || got.done !== want.done ||
                got.total !== want.total || got.last !== want.last)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("[%0t] mismatch: exp idx %0d done %0b tot %0d last %0b, %s",
                             $realtime, want.index, want.done, want.total, want.last,
                             $sformatf("got idx %0d done %0b tot %0d last %0b",
                                       got.index, got.done, got.total, got.last));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Source side: offers queued bytes, predicts on acceptance, and opens
    // random gaps between items.
    // ------------------------------------------------------------------
    initial
    begin
        s_tvalid = 1'b0;
        s_tdata  = '0;
        src_gap  = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (s_tvalid && s_tready)
            begin
                predict_byte_results(s_tdata);
                void'(byte_fifo.pop_front());
                items_accepted++;
                if (!quiet && $urandom_range(0, 3) == 0)
                    src_gap = $urandom_range(1, 8);
            end
            if (src_gap > 0)
            begin
                src_gap--;
                s_tvalid <= 1'b0;
            end
            else if (byte_fifo.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= byte_fifo[0];
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sink side: checks every accepted item, back-pressure in bursts.
    // ------------------------------------------------------------------
    initial
    begin
        m_tready = 1'b0;
        sink_gap = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                check_result('{index: m_tdata[31:0], done: m_tuser,
                               total: m_tdata[63:32], last: m_tlast});
            if (sink_gap > 0)
            begin
                sink_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0)
                    sink_gap = $urandom_range(1, 8);
            end
        end
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("bitmap_to_index_list regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Shared helpers
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] sel);
        byte_fifo.push_back(sel);
        items_sent++;
    endtask

    // Block is idle once every byte is taken, every result is in, and a
    // byte that caused nothing has had time to finish its walk.
    task automatic wait_idle();
        while (byte_fifo.size() > 0 || s_tvalid || pending_results.size() > 0)
            @(posedge clk);
        repeat (IDLE_PAUSE) @(posedge clk);
    endtask

    task automatic write_count(input logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        model_count  = value;
        count_writes++;
    endtask

    function automatic logic [7:0] random_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // count is zero out of reset: every byte only closes, total 0
    task automatic test_reset_count();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hA5);
        wait_idle();
    endtask

    // short bitmaps: partial last byte, empty bytes, full bytes
    task automatic test_short_bitmaps();
        write_count(32'd1);
        send_byte(8'hFF);               // index 0 only, rest ignored
        send_byte(8'hFE);               // nothing below the count, close only
        wait_idle();
        write_count(32'd8);
        send_byte(8'hFF);
        send_byte(8'h80);
        wait_idle();
        write_count(32'd9);
        send_byte(8'h00);               // not final, no selection: silent
        send_byte(8'hFF);               // index 8 then close
        wait_idle();
        write_count(32'd13);
        send_byte(8'h55);
        send_byte(8'hFF);
        wait_idle();
    endtask

    // count changed between bytes of one bitmap
    task automatic test_count_change();
        write_count(32'd24);
        send_byte(8'hFF);
        send_byte(8'hFF);
        wait_idle();
        write_count(32'd10);            // already past the new final byte
        send_byte(8'h0F);
        wait_idle();
        write_count(32'd24);
        send_byte(8'hFF);
        send_byte(8'h01);
        wait_idle();
        write_count('0);                // empty bitmap with a running total
        send_byte(8'h3C);
        wait_idle();
        write_count(32'hFFFF_FFFF);     // widest count, never reaches its end here
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hC3);
        wait_idle();
        write_count(32'h8000_0000);
        send_byte(8'h81);
        wait_idle();
        write_count(32'd1);             // forces the close
        send_byte(8'h7E);
        wait_idle();
    endtask

    // mostly whole bitmaps with random content, some cut short or reshaped
    task automatic test_random_bitmaps();
        int          target;
        logic [31:0] count;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            if (items_sent >= target - QUIET_TAIL)
                quiet = 1'b1;
            wait_idle();
            case ($urandom_range(0, 9))
                0:
                begin
                    write_count('0);
                    repeat ($urandom_range(1, 3)) send_byte(random_byte());
                end
                1:
                begin
                    // any count, a few bytes, then one more byte under a small count
                    write_count($urandom);
                    repeat ($urandom_range(1, 4)) send_byte(random_byte());
                    wait_idle();
                    write_count($urandom_range(1, 40));
                    send_byte(random_byte());
                end
                2:
                begin
                    // bitmap abandoned part way for a new count
                    write_count($urandom_range(17, 64));
                    repeat ($urandom_range(1, 2)) send_byte(random_byte());
                    wait_idle();
                    count = $urandom_range(1, 64);
                    write_count(count);
                    repeat ((count + 7) / 8) send_byte(random_byte());
                end
                default:
                begin
                    count = ($urandom_range(0, 4) == 0) ? $urandom_range(65, 200)
                                                       : $urandom_range(1, 64);
                    write_count(count);
                    repeat ((count + 7) / 8) send_byte(random_byte());
                end
            endcase
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        model_count    = '0;
        model_pos      = '0;
        model_selected = '0;
        quiet          = 1'b0;
        items_sent     = 0;
        items_accepted = 0;
        results_checked = 0;
        closes_seen    = 0;
        count_writes   = 0;
        mismatch_count = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_count();
        test_short_bitmaps();
        test_count_change();
        test_random_bitmaps();

        // anything still predicted now never arrived
        if (pending_results.size() > 0)
        begin
            $display("%0d predicted items never arrived", pending_results.size());
            mismatch_count += pending_results.size();
        end

        $display("run covered %0d bytes over %0d count settings", items_accepted,
                 count_writes);
        $display("%0d result items checked, %0d of them closing, %0d mismatches",
                 results_checked, closes_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("bitmap_to_index_list regression: pass");
        else
            $display("bitmap_to_index_list regression: fail");
        $finish;
    end

endmodule
